// ===== hw/rtl/bplst_pkg.sv =====
`default_nettype none

package bplst_pkg;

  // List geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 4;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned OUT_CNT_W = 5;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  // Common width for comparing positions against the occupancy
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AFTER = 4'd2,
    OP_DEL_FRONT = 4'd3,
    OP_DEL_BACK  = 4'd4,
    OP_DEL_AT    = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_CLEAR     = 4'd7,
    OP_PEEK      = 4'd8
  } op_e;

  // What one cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_e;

endpackage

`default_nettype wire

// ===== hw/rtl/bplst_cell.sv =====
`default_nettype none

module bplst_cell (
  input  wire logic                                clk_i,
  input  wire bplst_pkg::cell_op_e                 cell_op_i,
  input  wire logic signed [bplst_pkg::DATA_W-1:0] value_i,
  input  wire logic signed [bplst_pkg::DATA_W-1:0] prev_data_i,
  input  wire logic signed [bplst_pkg::DATA_W-1:0] next_data_i,
  output logic signed      [bplst_pkg::DATA_W-1:0] data_o,
  output logic                                     match_o
);
  import bplst_pkg::*;

  logic signed [DATA_W-1:0] data_q;
  logic signed [DATA_W-1:0] data_d;

  // Next content: keep, take the new value, or take a neighbor's
  always_comb begin
    case (cell_op_i)
      CELL_HOLD:      data_d = data_q;
      CELL_LOAD:      data_d = value_i;
      CELL_FROM_PREV: data_d = prev_data_i;
      CELL_FROM_NEXT: data_d = next_data_i;
      default:        data_d = data_q;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == value_i);

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_positional_list_stack.sv =====
// Bounded positional list used as a stack: up to DEPTH signed 32-bit
// entries, position 1 (the front) is the top.
// Input channel: in_valid_i / in_stall_o carry one request (operation,
// position, value). Output channel: out_valid_o / out_stall_i carry one
// result per request (status, found, top_value, count, empty_res).
// A request is taken when valid is high and stall is low at a rising edge.
// The entries sit in a row of cells; an insert or delete shifts every cell
// past the affected position by one place toward its neighbor in the same
// cycle, and a search compares all cells at once against the key.
// The result is registered: it is valid right after the accepting edge.
// Throughput is one request per cycle while the receiver takes results; the
// single result register sets that figure.
// While the receiver stalls a pending result, the input channel stalls too
// and the result and list contents hold.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending
// result; entry contents are not cleared, only the occupancy.
`default_nettype none

module bounded_positional_list_stack (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [bplst_pkg::OP_W-1:0]          operation_i,
  input  wire logic [bplst_pkg::POS_W-1:0]         position_i,
  input  wire logic signed [bplst_pkg::DATA_W-1:0] value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     status_o,
  output logic                                     found_o,
  output logic signed [bplst_pkg::DATA_W-1:0]      top_value_o,
  output logic [bplst_pkg::OUT_CNT_W-1:0]          count_o,
  output logic                                     empty_res_o
);
  import bplst_pkg::*;

  logic             in_acc;
  logic             out_acc;
  logic             done_q;
  logic             done_d;
  logic [CNT_W-1:0] occ_q;
  logic [CNT_W-1:0] occ_d;
  logic             fail_q;
  logic             fail_d;
  logic             srch_q;
  logic             srch_d;
  logic [DEPTH-1:0] match_q;
  logic [DEPTH-1:0] match_d;
  logic [DEPTH-1:0] cell_match;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  cell_op_e                 cell_op   [DEPTH];

  // Decode helpers
  logic             do_ins;
  logic             do_del;
  logic [CMP_W-1:0] ins_idx;
  logic [CMP_W-1:0] del_idx;
  logic [CMP_W-1:0] occ_w;
  logic [CMP_W-1:0] pos_w;
  logic             room;
  logic             nonempty;

  assign out_acc    = done_q & ~out_stall_i;
  assign in_stall_o = done_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign occ_w    = CMP_W'(occ_q);
  assign pos_w    = CMP_W'(position_i);
  assign room     = (occ_q < CNT_W'(DEPTH));
  assign nonempty = (occ_q != '0);

  // Operation decode: which shift to make, the new occupancy and the result flags
  always_comb begin
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_idx = '0;
    del_idx = '0;
    occ_d   = occ_q;
    fail_d  = 1'b1;
    srch_d  = 1'b0;
    case (op_e'(operation_i))
      OP_INS_FRONT: begin
        do_ins  = room;
        ins_idx = '0;
      end
      OP_INS_BACK: begin
        do_ins  = room;
        ins_idx = occ_w;
      end
      OP_INS_AFTER: begin
        do_ins  = room && (pos_w <= occ_w);
        ins_idx = pos_w;
      end
      OP_DEL_FRONT: begin
        do_del  = nonempty;
        del_idx = '0;
      end
      OP_DEL_BACK: begin
        // Dropping the last entry needs no shift
        if (nonempty) begin
          occ_d  = occ_q - CNT_W'(1);
          fail_d = 1'b0;
        end
      end
      OP_DEL_AT: begin
        do_del  = (pos_w != '0) && (pos_w <= occ_w);
        del_idx = pos_w - CMP_W'(1);
      end
      OP_SEARCH: begin
        srch_d = 1'b1;
      end
      OP_CLEAR: begin
        occ_d  = '0;
        fail_d = 1'b0;
      end
      OP_PEEK: begin
        fail_d = 1'b0;
      end
      default: begin
        fail_d = 1'b1;
      end
    endcase
    if (do_ins) begin
      occ_d  = occ_q + CNT_W'(1);
      fail_d = 1'b0;
    end
    if (do_del) begin
      occ_d  = occ_q - CNT_W'(1);
      fail_d = 1'b0;
    end
  end

  // Per-cell shift control and masked match bits
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (in_acc && do_ins) begin
        if (CMP_W'(i) == ins_idx) begin
          cell_op[i] = CELL_LOAD;
        end else if ((CMP_W'(i) > ins_idx) && (CMP_W'(i) <= occ_w)) begin
          cell_op[i] = CELL_FROM_PREV;
        end
      end else if (in_acc && do_del) begin
        if ((CMP_W'(i) >= del_idx) && (CMP_W'(i) + CMP_W'(1) < occ_w)) begin
          cell_op[i] = CELL_FROM_NEXT;
        end
      end
      match_d[i] = cell_match[i] && (CMP_W'(i) < occ_w);
    end
  end

  // Row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] prev_data;
    logic signed [DATA_W-1:0] next_data;

    if (g == 0) begin : g_first
      assign prev_data = value_i;
    end else begin : g_mid
      assign prev_data = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_data = cell_data[g];
    end else begin : g_inner
      assign next_data = cell_data[g+1];
    end

    bplst_cell u_cell (
      .clk_i       (clk_i),
      .cell_op_i   (cell_op[g]),
      .value_i     (value_i),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g]),
      .match_o     (cell_match[g])
    );
  end

  // Result pending flag
  always_comb begin
    done_d = done_q;
    if (in_acc) begin
      done_d = 1'b1;
    end else if (out_acc) begin
      done_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      occ_q  <= '0;
    end else begin
      done_q <= done_d;
      if (in_acc) begin
        occ_q <= occ_d;
      end
    end
  end

  // Per-request result bits
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fail_q  <= fail_d;
      srch_q  <= srch_d;
      match_q <= match_d;
    end
  end

  // Result fields
  always_comb begin
    found_o     = srch_q && (|match_q);
    status_o    = srch_q ? ~(|match_q) : fail_q;
    top_value_o = nonempty ? cell_data[0] : -32'sd1;
    count_o     = OUT_CNT_W'(occ_q);
    empty_res_o = ~nonempty;
    out_valid_o = done_q;
  end

  // Checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_CLEAR) |=> (occ_q == '0) && empty_res_o)
    else $error("clear left entries");

  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_INS_FRONT) && room
    |=> (top_value_o == $past(value_i)) && (occ_q == $past(occ_q) + CNT_W'(1)))
    else $error("front insert did not land on top");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(occ_q) && out_valid_o)
    else $error("state moved while result stalled");

endmodule

`default_nettype wire
